// ----- sv/sync_framed_checksum_receiver_defines.svh -----
// ----------------------------------------------------------------------------
// Sync-framed checksum receiver: assertion macros
// Shared property wrappers clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef SYNC_FRAMED_CHECKSUM_RECEIVER_DEFINES_SVH
`define SYNC_FRAMED_CHECKSUM_RECEIVER_DEFINES_SVH

// Same-cycle implication, checked at every rising edge of clk.
`define SFCR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge of clk.
`define SFCR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/sfcr_pkg.sv -----
// ----------------------------------------------------------------------------
// sfcr_pkg
// Types and constants shared by the sync-framed checksum receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package sfcr_pkg;

  localparam int FRAME_BYTES_DEFAULT = 16;

  localparam int BYTE_W  = 8;
  localparam int SUM_W   = 16;
  localparam int POS_W   = 6;
  localparam int CFG_IDX_W = 1;

  localparam logic [BYTE_W-1:0] SYNC_RESET   = 8'h0A;
  localparam logic [BYTE_W-1:0] TARGET_RESET = 8'hFF;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 1'd1;

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_COLLECT,
    ST_READ,
    ST_EMIT,
    ST_BAD
  } state_t;

  // Output register load request from the sequencer
  typedef struct packed {
    logic load;
    logic good;
    logic last;
  } load_t;

endpackage

`default_nettype wire

// ----- sv/sfcr_ram.sv -----
// ----------------------------------------------------------------------------
// sfcr_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sfcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    // hold read data until the next read
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/sfcr_ctrl.sv -----
// ----------------------------------------------------------------------------
// sfcr_ctrl
// Hunt/collect/replay sequencer: byte counter, running sum, frame RAM access.
// ----------------------------------------------------------------------------
`default_nettype none

module sfcr_ctrl #(
  parameter int FRAME_BYTES = sfcr_pkg::FRAME_BYTES_DEFAULT,
  localparam int AW = $clog2(FRAME_BYTES)
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         rx_valid,
  input  wire logic [sfcr_pkg::BYTE_W-1:0]  rx_byte,
  output logic                              rx_stall,
  input  wire logic [sfcr_pkg::BYTE_W-1:0]  sync_value,
  input  wire logic [sfcr_pkg::BYTE_W-1:0]  check_target,
  input  wire logic                         out_free,
  output logic                              ram_we,
  output logic                              ram_re,
  output logic [AW-1:0]                     ram_addr,
  output logic [sfcr_pkg::BYTE_W-1:0]       ram_wdata,
  output sfcr_pkg::load_t                   ld,
  output logic [AW-1:0]                     ld_pos
);

  localparam logic [AW-1:0] LAST_IDX = AW'(FRAME_BYTES - 1);

  sfcr_pkg::state_t             state, state_next;
  logic [AW-1:0]                count, count_next;
  logic [sfcr_pkg::SUM_W-1:0]   sum, sum_next;
  logic [sfcr_pkg::SUM_W-1:0]   sum_add;
  logic [sfcr_pkg::BYTE_W-1:0]  fold;
  logic                         accept;
  logic                         at_last;
  logic                         sum_ok;

  assign accept  = rx_valid && !rx_stall;
  assign at_last = (count == LAST_IDX);
  assign sum_add = sum + sfcr_pkg::SUM_W'(rx_byte);
  // fold of the sum that includes the current byte: low byte plus high byte, carry dropped
  assign fold    = sum_add[7:0] + sum_add[15:8];
  assign sum_ok  = (fold == check_target);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      sfcr_pkg::ST_HUNT: begin
        if (accept && rx_byte == sync_value) state_next = sfcr_pkg::ST_COLLECT;
      end
      sfcr_pkg::ST_COLLECT: begin
        if (accept && at_last) begin
          state_next = sum_ok ? sfcr_pkg::ST_READ : sfcr_pkg::ST_BAD;
        end
      end
      sfcr_pkg::ST_READ: begin
        state_next = sfcr_pkg::ST_EMIT;
      end
      sfcr_pkg::ST_EMIT: begin
        if (out_free) state_next = at_last ? sfcr_pkg::ST_HUNT : sfcr_pkg::ST_READ;
      end
      sfcr_pkg::ST_BAD: begin
        if (out_free) state_next = sfcr_pkg::ST_HUNT;
      end
      default: state_next = sfcr_pkg::ST_HUNT;
    endcase
  end

  // counter and sum; the counter doubles as the replay pointer
  always_comb begin
    count_next = count;
    sum_next   = sum;
    unique case (state)
      sfcr_pkg::ST_HUNT: begin
        if (accept && rx_byte == sync_value) begin
          count_next = '0;
          sum_next   = '0;
        end
      end
      sfcr_pkg::ST_COLLECT: begin
        if (accept) begin
          sum_next   = sum_add;
          count_next = at_last ? '0 : count + AW'(1);
        end
      end
      sfcr_pkg::ST_EMIT: begin
        if (out_free) count_next = at_last ? '0 : count + AW'(1);
      end
      sfcr_pkg::ST_READ, sfcr_pkg::ST_BAD: begin
        count_next = count;
      end
      default: count_next = '0;
    endcase
  end

  // outputs
  always_comb begin
    rx_stall  = !(state == sfcr_pkg::ST_HUNT || state == sfcr_pkg::ST_COLLECT);
    ram_we    = accept && (state == sfcr_pkg::ST_COLLECT);
    ram_re    = (state == sfcr_pkg::ST_READ);
    ram_addr  = count;
    ram_wdata = rx_byte;
    ld.load   = out_free && (state == sfcr_pkg::ST_EMIT || state == sfcr_pkg::ST_BAD);
    ld.good   = (state == sfcr_pkg::ST_EMIT);
    ld.last   = (state == sfcr_pkg::ST_BAD) || at_last;
    ld_pos    = (state == sfcr_pkg::ST_BAD) ? '0 : count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sfcr_pkg::ST_HUNT;
      count <= '0;
      sum   <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      sum   <= sum_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/sync_framed_checksum_receiver.sv -----
// Timing: each good-frame result passes the READ state (frame RAM read) and the EMIT state
//   (output load); a bad-frame result is loaded from the BAD state. Both wait on a stall.
// Throughput: 1 byte per cycle while hunting or collecting; replay holds off input,
//   with one frame RAM read plus one output load per result.
// Reset: synchronous rst returns to hunting, restores sync 0x0A and target 0xFF,
//   empties the output register; the frame RAM is not cleared.
`default_nettype none

`include "sync_framed_checksum_receiver_defines.svh"

// ----------------------------------------------------------------------------
// sync_framed_checksum_receiver
// Hunts for a sync byte, collects a fixed-length frame into RAM while summing
// it, checks the folded sum and replays the frame or flags it bad.
// ----------------------------------------------------------------------------
module sync_framed_checksum_receiver #(
  parameter int FRAME_BYTES = sfcr_pkg::FRAME_BYTES_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // received byte channel
  input  wire logic                           rx_valid,
  output logic                                rx_stall,
  input  wire logic [sfcr_pkg::BYTE_W-1:0]    rx_byte,
  // frame result channel
  output logic                                frame_valid,
  input  wire logic                           frame_stall,
  output logic      [sfcr_pkg::BYTE_W-1:0]    frame_byte,
  output logic      [sfcr_pkg::POS_W-1:0]     byte_position,
  output logic                                last_of_frame,
  output logic                                checksum_good,
  // configuration writes
  input  wire logic                           cfg_write_en,
  input  wire logic [sfcr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sfcr_pkg::BYTE_W-1:0]    cfg_data
);

  localparam int AW = $clog2(FRAME_BYTES);

  logic [sfcr_pkg::BYTE_W-1:0] sync_value;
  logic [sfcr_pkg::BYTE_W-1:0] check_target;

  logic                        ram_we;
  logic                        ram_re;
  logic [AW-1:0]               ram_addr;
  logic [sfcr_pkg::BYTE_W-1:0] ram_wdata;
  logic [sfcr_pkg::BYTE_W-1:0] ram_rdata;

  sfcr_pkg::load_t             ld;
  logic [AW-1:0]               ld_pos;
  logic                        out_free;

  // Output register is free when empty or when its transfer completes now.
  assign out_free = !frame_valid || !frame_stall;

  // Configuration registers; writes take effect from the next byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_value   <= sfcr_pkg::SYNC_RESET;
      check_target <= sfcr_pkg::TARGET_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        sfcr_pkg::CFG_SYNC:   sync_value   <= cfg_data;
        sfcr_pkg::CFG_TARGET: check_target <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer: collection writes and replay reads never share a cycle, and
  // each replay read is consumed before the next is issued, so the frame RAM
  // needs no forwarding path.
  sfcr_ctrl #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .rx_valid     (rx_valid),
    .rx_byte      (rx_byte),
    .rx_stall     (rx_stall),
    .sync_value   (sync_value),
    .check_target (check_target),
    .out_free     (out_free),
    .ram_we       (ram_we),
    .ram_re       (ram_re),
    .ram_addr     (ram_addr),
    .ram_wdata    (ram_wdata),
    .ld           (ld),
    .ld_pos       (ld_pos)
  );

  // Frame store: one byte per entry, indexed by position in the frame.
  sfcr_ram #(
    .WIDTH (sfcr_pkg::BYTE_W),
    .DEPTH (FRAME_BYTES)
  ) u_frame_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Output register: valid is control, the payload needs no reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (ld.load) begin
      frame_valid <= 1'b1;
    end else if (!frame_stall) begin
      frame_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld.load) begin
      // bad frame carries a zero byte at position zero
      frame_byte    <= ld.good ? ram_rdata : '0;
      byte_position <= sfcr_pkg::POS_W'(ld_pos);
      last_of_frame <= ld.last;
      checksum_good <= ld.good;
    end
  end

  // Collection and replay must never touch the RAM in the same cycle.
  `SFCR_ASSERT_NOW(a_ram_excl, ram_we, !ram_re, "frame RAM write and read overlap")

  // A rejected frame reports one zero result at position zero, marked last.
  `SFCR_ASSERT_NOW(a_bad_shape, frame_valid && !checksum_good,
    frame_byte == '0 && byte_position == '0 && last_of_frame, "malformed bad-frame result")

  // A replay read is always followed by an output load attempt, never input.
  `SFCR_ASSERT_NEXT(a_read_then_emit, ram_re, rx_stall && !ram_re,
    "replay read not followed by emit")

endmodule

`default_nettype wire
